>>> src/ngbo_pkg.sv
// ----------------------------------------------------------------------------
// ngbo_pkg
// Shared types and constants for the n-gram back-off lookup.
// ----------------------------------------------------------------------------
package ngbo_pkg;

   localparam int GRAM_WORDS = 4;
   localparam int WORD_W     = 16;
   localparam int LOG_W      = 32;
   localparam int CS_W       = 17;
   localparam int CFG_W      = 17;
   localparam int LEN_W      = 3;
   localparam int NODE_W     = WORD_W + LOG_W + LOG_W + CS_W;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic CSR_VOCAB_SIZE = 1'b0;
   localparam logic CSR_NODE_COUNT = 1'b1;

   typedef struct packed {
      logic                                is_query;
      logic                                bad;
      logic [LEN_W-1:0]                    len;
      logic [WORD_W-1:0]                   addr;
      logic [WORD_W-1:0]                   word;
      logic signed [LOG_W-1:0]             node_lp;
      logic signed [LOG_W-1:0]             node_bo;
      logic signed [CS_W-1:0]              child_start;
      logic [GRAM_WORDS-1:0][WORD_W-1:0]   words;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_STEP,
      ST_CS_LO,
      ST_CS_HI,
      ST_SEARCH,
      ST_BIN,
      ST_LIN,
      ST_END,
      ST_ACC,
      ST_RESULT
   } state_type;

endpackage

>>> src/ngbo_front.sv
// ----------------------------------------------------------------------------
// ngbo_front
// Configuration registers, request classification and word range check.
// ----------------------------------------------------------------------------
module ngbo_front import ngbo_pkg::*; #(
   parameter int MAX_ORDER = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic                    csr_addr,
   input  logic [CFG_W-1:0]        csr_wdata,
   input  logic                    req_type,
   input  logic [WORD_W-1:0]       req_node_addr,
   input  logic [WORD_W-1:0]       req_node_word,
   input  logic signed [LOG_W-1:0] req_node_log_prob,
   input  logic signed [LOG_W-1:0] req_node_back_off,
   input  logic signed [CS_W-1:0]  req_node_child_start,
   input  logic [LEN_W-1:0]        req_gram_len,
   input  logic [WORD_W-1:0]       req_gram_word_0,
   input  logic [WORD_W-1:0]       req_gram_word_1,
   input  logic [WORD_W-1:0]       req_gram_word_2,
   input  logic [WORD_W-1:0]       req_gram_word_3,
   output cmd_type                 cmd,
   output logic [CFG_W-1:0]        node_count
);

   localparam int MAXLEN = (MAX_ORDER < GRAM_WORDS) ? MAX_ORDER : GRAM_WORDS;

   logic [CFG_W-1:0] vocab_ff, vocab_in;
   logic [CFG_W-1:0] nodes_ff, nodes_in;
   logic [LEN_W-1:0] len;
   logic             bad;
   logic [GRAM_WORDS-1:0][WORD_W-1:0] words;

   always_ff @(posedge clock) begin
      if (reset) begin
         vocab_ff <= CFG_W'(1);
         nodes_ff <= CFG_W'(1);
      end else begin
         vocab_ff <= vocab_in;
         nodes_ff <= nodes_in;
      end
   end

   always_comb begin
      vocab_in = vocab_ff;
      nodes_in = nodes_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_VOCAB_SIZE: vocab_in = csr_wdata;
            CSR_NODE_COUNT: nodes_in = csr_wdata;
            default: ;
         endcase
      end
   end

   assign words = {req_gram_word_3, req_gram_word_2, req_gram_word_1, req_gram_word_0};

   always_comb begin
      if (req_gram_len == '0) begin
         len = LEN_W'(1);
      end else if (req_gram_len > LEN_W'(MAXLEN)) begin
         len = LEN_W'(MAXLEN);
      end else begin
         len = req_gram_len;
      end
      bad = 1'b0;
      for (int k = 0; k < GRAM_WORDS; k++) begin
         if ((LEN_W'(k) < len) && ({1'b0, words[k]} >= vocab_ff)) begin
            bad = 1'b1;
         end
      end
   end

   always_comb begin
      cmd.is_query    = (req_type == REQ_QUERY);
      cmd.bad         = bad;
      cmd.len         = len;
      cmd.addr        = req_node_addr;
      cmd.word        = req_node_word;
      cmd.node_lp     = req_node_log_prob;
      cmd.node_bo     = req_node_back_off;
      cmd.child_start = req_node_child_start;
      cmd.words       = words;
   end

   assign node_count = nodes_ff;

endmodule

>>> src/ngbo_fifo.sv
// ----------------------------------------------------------------------------
// ngbo_fifo
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module ngbo_fifo import ngbo_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty
);

   cmd_type    slot_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff ^ do_push;
      rptr_in  = rptr_ff ^ do_pop;
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

endmodule

>>> src/ngbo_back.sv
// ----------------------------------------------------------------------------
// ngbo_back
// Node table and lookup sequencer: path walk, child search, score sum.
// ----------------------------------------------------------------------------
module ngbo_back import ngbo_pkg::*; #(
   parameter int NODE_DEPTH   = 65536,
   parameter int LINEAR_LIMIT = 5
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [CFG_W-1:0]        node_count,
   input  cmd_type                 cmd,
   input  logic                    cmd_empty,
   output logic                    cmd_pop,
   output logic signed [LOG_W-1:0] rsp_total_log_prob,
   output logic [LEN_W-1:0]        rsp_matched_order,
   output logic                    rsp_bad_word,
   output logic                    empty,
   input  logic                    pop
);

   localparam int AW = $clog2(NODE_DEPTH);
   localparam int XW = ((AW > CS_W) ? AW : CS_W) + 1;
   localparam int IW = CS_W;

   logic [NODE_W-1:0] mem [NODE_DEPTH];
   logic [NODE_W-1:0] rdata_ff;
   logic              rvalid_ff;

   logic [IW-1:0]     rd_idx;
   logic [XW-1:0]     rd_ext, wr_ext;
   logic              wr_en;

   logic [WORD_W-1:0]       d_word;
   logic signed [LOG_W-1:0] d_lp, d_bo;
   logic signed [CS_W-1:0]  d_cs;

   state_type state_ff, state_in;
   logic [LEN_W-1:0] len_ff, len_in, n_ff, n_in, i_ff, i_in, found_ff, found_in;
   logic [LEN_W-1:0] order_ff, order_in;
   logic [GRAM_WORDS-1:0][WORD_W-1:0] words_ff, words_in;
   logic [IW-1:0]    prev_ff, prev_in, deep_ff, deep_in;
   logic [IW-1:0]    lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic             prev_v_ff, prev_v_in, deep_v_ff, deep_v_in, acc_lp_ff, acc_lp_in;
   logic             bad_ff, bad_in;
   logic signed [LOG_W-1:0] sum_ff, sum_in;
   logic             out_v_ff, out_v_in;
   logic signed [LOG_W-1:0] out_sum_ff, out_sum_in;
   logic [LEN_W-1:0] out_order_ff, out_order_in;
   logic             out_bad_ff, out_bad_in;

   logic             hit, miss;
   logic [IW-1:0]    hit_node;
   logic [WORD_W-1:0] cur_word;
   logic signed [IW+1:0] span, lim;
   logic signed [LOG_W:0] add_val, wide_sum;
   logic [LEN_W-1:0] rem;

   assign rd_ext = XW'(rd_idx);
   assign wr_ext = XW'(cmd.addr);

   always_ff @(posedge clock) begin
      if (wr_en && (wr_ext < XW'(NODE_DEPTH))) begin
         mem[wr_ext[AW-1:0]] <= {cmd.word, cmd.node_lp, cmd.node_bo, cmd.child_start};
      end
      rdata_ff  <= mem[rd_ext[AW-1:0]];
      rvalid_ff <= (rd_ext < XW'(NODE_DEPTH));
   end

   always_comb begin
      if (rvalid_ff) begin
         {d_word, d_lp, d_bo, d_cs} = rdata_ff;
      end else begin
         {d_word, d_lp, d_bo, d_cs} = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
      end
      len_ff       <= len_in;
      n_ff         <= n_in;
      i_ff         <= i_in;
      found_ff     <= found_in;
      order_ff     <= order_in;
      words_ff     <= words_in;
      prev_ff      <= prev_in;
      deep_ff      <= deep_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      prev_v_ff    <= prev_v_in;
      deep_v_ff    <= deep_v_in;
      acc_lp_ff    <= acc_lp_in;
      bad_ff       <= bad_in;
      sum_ff       <= sum_in;
      out_sum_ff   <= out_sum_in;
      out_order_ff <= out_order_in;
      out_bad_ff   <= out_bad_in;
   end

   assign cur_word = words_ff[i_ff[1:0]];
   assign span     = $signed({2'b00, hi_ff}) - $signed({2'b00, lo_ff});
   assign lim      = $signed({2'b00, node_count}) - $signed((IW+2)'(1));
   assign rem      = len_ff - n_ff;
   assign add_val  = acc_lp_ff ? {d_lp[LOG_W-1], d_lp} : {d_bo[LOG_W-1], d_bo};
   assign wide_sum = {sum_ff[LOG_W-1], sum_ff} + add_val;

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      found_in     = found_ff;
      order_in     = order_ff;
      words_in     = words_ff;
      prev_in      = prev_ff;
      deep_in      = deep_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      prev_v_in    = prev_v_ff;
      deep_v_in    = deep_v_ff;
      acc_lp_in    = acc_lp_ff;
      bad_in       = bad_ff;
      sum_in       = sum_ff;
      out_v_in     = out_v_ff && !pop;
      out_sum_in   = out_sum_ff;
      out_order_in = out_order_ff;
      out_bad_in   = out_bad_ff;
      cmd_pop      = 1'b0;
      wr_en        = 1'b0;
      rd_idx       = '0;
      hit          = 1'b0;
      miss         = 1'b0;
      hit_node     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               if (!cmd.is_query) begin
                  wr_en = 1'b1;
               end else begin
                  len_in    = cmd.len;
                  words_in  = cmd.words;
                  n_in      = '0;
                  i_in      = '0;
                  found_in  = '0;
                  prev_v_in = 1'b0;
                  deep_v_in = 1'b0;
                  sum_in    = '0;
                  order_in  = LEN_W'(1);
                  bad_in    = cmd.bad;
                  state_in  = cmd.bad ? ST_RESULT : ST_STEP;
               end
            end
         end
         ST_STEP: begin
            if (!prev_v_ff) begin
               hit      = 1'b1;
               hit_node = IW'(cur_word);
            end else if ($signed({2'b00, prev_ff}) >= lim) begin
               miss = 1'b1;
            end else begin
               rd_idx   = prev_ff;
               state_in = ST_CS_LO;
            end
         end
         ST_CS_LO: begin
            lo_in    = d_cs;
            rd_idx   = prev_ff + IW'(1);
            state_in = ST_CS_HI;
         end
         ST_CS_HI: begin
            if (lo_ff[IW-1] || d_cs[CS_W-1]) begin
               miss = 1'b1;
            end else begin
               hi_in    = d_cs;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (span > (IW+2)'(LINEAR_LIMIT)) begin
               mid_in   = lo_ff + span[IW:1];
               rd_idx   = lo_ff + span[IW:1];
               state_in = ST_BIN;
            end else if (lo_ff < hi_ff) begin
               rd_idx   = lo_ff;
               state_in = ST_LIN;
            end else begin
               miss = 1'b1;
            end
         end
         ST_BIN: begin
            if (d_word == cur_word) begin
               hit      = 1'b1;
               hit_node = mid_ff;
            end else if (d_word > cur_word) begin
               hi_in    = mid_ff;
               state_in = ST_SEARCH;
            end else begin
               lo_in    = mid_ff + IW'(1);
               state_in = ST_SEARCH;
            end
         end
         ST_LIN: begin
            if (d_word == cur_word) begin
               hit      = 1'b1;
               hit_node = lo_ff;
            end else begin
               lo_in    = lo_ff + IW'(1);
               state_in = ST_SEARCH;
            end
         end
         ST_END: begin
            if (found_ff == rem) begin
               rd_idx    = deep_ff;
               acc_lp_in = 1'b1;
               order_in  = rem;
               state_in  = ST_ACC;
            end else if ((found_ff == rem - LEN_W'(1)) && deep_v_ff) begin
               rd_idx    = deep_ff;
               acc_lp_in = 1'b0;
               state_in  = ST_ACC;
            end else begin
               n_in      = n_ff + LEN_W'(1);
               i_in      = n_ff + LEN_W'(1);
               found_in  = '0;
               prev_v_in = 1'b0;
               deep_v_in = 1'b0;
               state_in  = ST_STEP;
            end
         end
         ST_ACC: begin
            if (wide_sum > $signed({1'b0, {(LOG_W-1){1'b1}}})) begin
               sum_in = {1'b0, {(LOG_W-1){1'b1}}};
            end else if (wide_sum < $signed({2'b11, {(LOG_W-1){1'b0}}})) begin
               sum_in = {1'b1, {(LOG_W-1){1'b0}}};
            end else begin
               sum_in = wide_sum[LOG_W-1:0];
            end
            if (acc_lp_ff) begin
               state_in = ST_RESULT;
            end else begin
               n_in      = n_ff + LEN_W'(1);
               i_in      = n_ff + LEN_W'(1);
               found_in  = '0;
               prev_v_in = 1'b0;
               deep_v_in = 1'b0;
               state_in  = ST_STEP;
            end
         end
         ST_RESULT: begin
            if (!out_v_ff || pop) begin
               out_v_in     = 1'b1;
               out_sum_in   = sum_ff;
               out_order_in = order_ff;
               out_bad_in   = bad_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (hit) begin
         found_in  = found_ff + LEN_W'(1);
         deep_in   = hit_node;
         deep_v_in = 1'b1;
         prev_in   = hit_node;
         prev_v_in = 1'b1;
         i_in      = i_ff + LEN_W'(1);
         state_in  = (i_ff + LEN_W'(1) == len_ff) ? ST_END : ST_STEP;
      end
      if (miss) begin
         state_in = ST_END;
      end
   end

   assign empty              = !out_v_ff;
   assign rsp_total_log_prob = out_sum_ff;
   assign rsp_matched_order  = out_order_ff;
   assign rsp_bad_word       = out_bad_ff;

endmodule

>>> src/ngram_backoff_lookup.sv
// ----------------------------------------------------------------------------
// ngram_backoff_lookup
// Back-off n-gram log-probability lookup over a flat node table.
// ----------------------------------------------------------------------------
// Node writes and queries share one input queue and are carried out in order.
// A write is carried out as it leaves the queue. A query walks up to
// len*(len+1)/2 path steps (ten for four words) through a single-port node
// table; each step after the unigram reads the parent's child start and the
// next node's child start, then runs a binary search, or a linear scan once
// the range is small, over the child range. A query with an out-of-vocabulary
// word goes straight to its result without a walk.
// One result waits in an output register while the next items are queued;
// a query finishing while that register is still full stalls until it is
// popped. No clearing pass.
// ----------------------------------------------------------------------------
module ngram_backoff_lookup import ngbo_pkg::*; #(
   parameter int NODE_DEPTH   = 65536,
   parameter int MAX_ORDER    = 4,
   parameter int LINEAR_LIMIT = 5
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic                    csr_addr,
   input  logic [CFG_W-1:0]        csr_wdata,
   input  logic                    push,
   output logic                    full,
   input  logic                    req_type,
   input  logic [WORD_W-1:0]       req_node_addr,
   input  logic [WORD_W-1:0]       req_node_word,
   input  logic signed [LOG_W-1:0] req_node_log_prob,
   input  logic signed [LOG_W-1:0] req_node_back_off,
   input  logic signed [CS_W-1:0]  req_node_child_start,
   input  logic [LEN_W-1:0]        req_gram_len,
   input  logic [WORD_W-1:0]       req_gram_word_0,
   input  logic [WORD_W-1:0]       req_gram_word_1,
   input  logic [WORD_W-1:0]       req_gram_word_2,
   input  logic [WORD_W-1:0]       req_gram_word_3,
   output logic                    empty,
   input  logic                    pop,
   output logic signed [LOG_W-1:0] rsp_total_log_prob,
   output logic [LEN_W-1:0]        rsp_matched_order,
   output logic                    rsp_bad_word
);

   cmd_type          front_cmd, back_cmd;
   logic [CFG_W-1:0] node_count;
   logic             q_empty, q_pop;

   ngbo_front #(.MAX_ORDER(MAX_ORDER)) u_front (
      .clock, .reset, .csr_we, .csr_addr, .csr_wdata,
      .req_type, .req_node_addr, .req_node_word, .req_node_log_prob,
      .req_node_back_off, .req_node_child_start, .req_gram_len,
      .req_gram_word_0, .req_gram_word_1, .req_gram_word_2, .req_gram_word_3,
      .cmd(front_cmd), .node_count
   );

   ngbo_fifo u_fifo (
      .clock, .reset,
      .push(push), .push_data(front_cmd), .full(full),
      .pop(q_pop), .pop_data(back_cmd), .empty(q_empty)
   );

   ngbo_back #(.NODE_DEPTH(NODE_DEPTH), .LINEAR_LIMIT(LINEAR_LIMIT)) u_back (
      .clock, .reset, .node_count,
      .cmd(back_cmd), .cmd_empty(q_empty), .cmd_pop(q_pop),
      .rsp_total_log_prob, .rsp_matched_order, .rsp_bad_word,
      .empty, .pop
   );

endmodule
